FILE: rtl/gf2_poly_inverse_assert.svh
// ----------------------------------------------------------------------------
// gf2_poly_inverse assertion macros
// Shared concurrent assertion forms for the polynomial inverter modules.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef GF2_POLY_INVERSE_ASSERT_SVH
`define GF2_POLY_INVERSE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GF2PI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GF2PI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gf2pi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2pi_pkg
// Types and constants shared by the polynomial inverter modules.
// ----------------------------------------------------------------------------
package gf2pi_pkg;

  // Reset value of the modulus register: x^8 + x^4 + x^3 + x^2 + 1.
  localparam logic [31:0] MODULUS_RESET = 32'h0000_011D;

  // Datapath commands issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_SETUP_EUC,
    CMD_SETUP_F1,
    CMD_SETUP_F2,
    CMD_ALIGN_SHIFT,
    CMD_DIV_STEP,
    CMD_EUC_UPD,
    CMD_CAPTURE
  } cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic a_zero;   // Euclid operand a is the zero polynomial.
    logic dv_zero;  // Divisor is the zero polynomial.
    logic dv_top;   // Divisor is aligned to the top bit.
    logic qm_last;  // Quotient pointer sits on bit zero.
  } sts_t;

endpackage

FILE: rtl/gf2pi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2pi channel interfaces
// Valid/ready channels for element input, inverse output and modulus writes.
// ----------------------------------------------------------------------------

interface gf2pi_in_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface gf2pi_out_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] inverse;

  modport source (output valid, output inverse, input ready);
  modport sink   (input valid, input inverse, output ready);
endinterface

interface gf2pi_cfg_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] modulus_poly;

  modport source (output valid, output modulus_poly, input ready);
  modport sink   (input valid, input modulus_poly, output ready);
endinterface

FILE: rtl/gf2pi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2pi_dp
// Euclid registers, bit-serial divider with Horner carry-less product, and
// the modulus and result registers.
// ----------------------------------------------------------------------------
`include "gf2_poly_inverse_assert.svh"

module gf2pi_dp #(
  parameter int W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gf2pi_pkg::cmd_t    cmd_i,
  output gf2pi_pkg::sts_t    sts_o,
  input  logic [W-1:0]       element_i,
  input  logic               cfg_we_i,
  input  logic [W-1:0]       cfg_data_i,
  output logic [W-1:0]       inverse_o
);

  logic [W-1:0] modulus_r;
  logic [W-1:0] g_r, g_nxt;
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] x_r, x_nxt;
  logic [W-1:0] s_r, s_nxt;
  logic [W-1:0] rm_r, rm_nxt;
  logic [W-1:0] dv_r, dv_nxt;
  logic [W-1:0] topm_r, topm_nxt;
  logic [W-1:0] qmask_r, qmask_nxt;
  logic [W-1:0] q_r, q_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] inv_r, inv_nxt;
  logic         div_bit;

  localparam logic [W-1:0] TOP_BIT = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE     = {{(W-1){1'b0}}, 1'b1};

  // The remainder bit under the divisor's leading term decides the step.
  assign div_bit = |(rm_r & topm_r);

  always_comb begin
    g_nxt     = g_r;
    a_nxt     = a_r;
    x_nxt     = x_r;
    s_nxt     = s_r;
    rm_nxt    = rm_r;
    dv_nxt    = dv_r;
    topm_nxt  = topm_r;
    qmask_nxt = qmask_r;
    q_nxt     = q_r;
    acc_nxt   = acc_r;
    inv_nxt   = inv_r;
    case (cmd_i)
      gf2pi_pkg::CMD_LOAD: begin
        g_nxt = modulus_r;
        a_nxt = element_i;
        x_nxt = '0;
        s_nxt = ONE;
      end
      gf2pi_pkg::CMD_SETUP_EUC, gf2pi_pkg::CMD_SETUP_F1, gf2pi_pkg::CMD_SETUP_F2: begin
        topm_nxt  = TOP_BIT;
        qmask_nxt = ONE;
        q_nxt     = '0;
        acc_nxt   = '0;
        if (cmd_i == gf2pi_pkg::CMD_SETUP_EUC) begin
          rm_nxt = g_r;
          dv_nxt = a_r;
        end else if (cmd_i == gf2pi_pkg::CMD_SETUP_F1) begin
          rm_nxt = modulus_r;
          dv_nxt = g_r;
        end else begin
          rm_nxt = x_r ^ modulus_r;
          dv_nxt = q_r;
        end
      end
      gf2pi_pkg::CMD_ALIGN_SHIFT: begin
        dv_nxt    = {dv_r[W-2:0], 1'b0};
        qmask_nxt = {qmask_r[W-2:0], 1'b0};
      end
      gf2pi_pkg::CMD_DIV_STEP: begin
        if (div_bit) begin
          rm_nxt = rm_r ^ dv_r;
          q_nxt  = q_r | qmask_r;
        end
        // Quotient bits arrive high to low, so the product with s is
        // built by Horner's rule, truncated to W bits at every step.
        acc_nxt   = {acc_r[W-2:0], 1'b0} ^ (div_bit ? s_r : '0);
        dv_nxt    = dv_r >> 1;
        topm_nxt  = topm_r >> 1;
        qmask_nxt = qmask_r >> 1;
      end
      gf2pi_pkg::CMD_EUC_UPD: begin
        g_nxt = a_r;
        a_nxt = rm_r;
        x_nxt = s_r;
        s_nxt = x_r ^ acc_r;
      end
      gf2pi_pkg::CMD_CAPTURE: begin
        inv_nxt = rm_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= W'(gf2pi_pkg::MODULUS_RESET);
    end else if (cfg_we_i) begin
      modulus_r <= cfg_data_i;
    end
  end

  always_ff @(posedge clk) begin
    g_r     <= g_nxt;
    a_r     <= a_nxt;
    x_r     <= x_nxt;
    s_r     <= s_nxt;
    rm_r    <= rm_nxt;
    dv_r    <= dv_nxt;
    topm_r  <= topm_nxt;
    qmask_r <= qmask_nxt;
    q_r     <= q_nxt;
    acc_r   <= acc_nxt;
    inv_r   <= inv_nxt;
  end

  assign sts_o.a_zero  = (a_r == '0);
  assign sts_o.dv_zero = (dv_r == '0);
  assign sts_o.dv_top  = dv_r[W-1];
  assign sts_o.qm_last = qmask_r[0];
  assign inverse_o     = inv_r;

  `GF2PI_ASSERT_IMPL(a_div_ptr_onehot, cmd_i == gf2pi_pkg::CMD_DIV_STEP, $onehot(qmask_r) && $onehot(topm_r), "division pointers lost their single set bit")
  `GF2PI_ASSERT_IMPL(a_div_lead_aligned, cmd_i == gf2pi_pkg::CMD_DIV_STEP, (dv_r & topm_r) != '0, "divisor leading term is not under the check position")
  `GF2PI_ASSERT_IMPL(a_align_nonzero, cmd_i == gf2pi_pkg::CMD_ALIGN_SHIFT, (dv_r != '0) && !dv_r[W-1], "alignment shift on a zero or already aligned divisor")

endmodule

FILE: rtl/gf2pi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2pi_ctrl
// Sequencer for the Euclid loop, the two closing divisions and the handshakes.
// ----------------------------------------------------------------------------
`include "gf2_poly_inverse_assert.svh"

module gf2pi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  gf2pi_pkg::sts_t  sts_i,
  output gf2pi_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ALIGN,
    S_DIV,
    S_AFTER
  } state_t;

  // Which division is in flight.
  typedef enum logic [1:0] {
    PH_EUC,
    PH_F1,
    PH_F2
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready_o  = (state_r == S_IDLE);
  assign out_valid_o = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready_i;
    cmd_o         = gf2pi_pkg::CMD_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o     = gf2pi_pkg::CMD_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.a_zero) begin
          cmd_o     = gf2pi_pkg::CMD_SETUP_F1;
          phase_nxt = PH_F1;
        end else begin
          cmd_o     = gf2pi_pkg::CMD_SETUP_EUC;
          phase_nxt = PH_EUC;
        end
        state_nxt = S_ALIGN;
      end
      S_ALIGN: begin
        if (sts_i.dv_zero) begin
          state_nxt = S_AFTER;
        end else if (sts_i.dv_top) begin
          state_nxt = S_DIV;
        end else begin
          cmd_o = gf2pi_pkg::CMD_ALIGN_SHIFT;
        end
      end
      S_DIV: begin
        cmd_o = gf2pi_pkg::CMD_DIV_STEP;
        if (sts_i.qm_last) begin
          state_nxt = S_AFTER;
        end
      end
      S_AFTER: begin
        case (phase_r)
          PH_EUC: begin
            cmd_o     = gf2pi_pkg::CMD_EUC_UPD;
            state_nxt = S_CHECK;
          end
          PH_F1: begin
            cmd_o     = gf2pi_pkg::CMD_SETUP_F2;
            phase_nxt = PH_F2;
            state_nxt = S_ALIGN;
          end
          default: begin
            if (!out_valid_r || out_ready_i) begin
              cmd_o         = gf2pi_pkg::CMD_CAPTURE;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_EUC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `GF2PI_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, (cmd_o == gf2pi_pkg::CMD_SETUP_EUC) || (cmd_o == gf2pi_pkg::CMD_SETUP_F1), "accepted beat did not start a division")
  `GF2PI_ASSERT_IMPL(a_upd_nonzero, cmd_o == gf2pi_pkg::CMD_EUC_UPD, !sts_i.a_zero, "Euclid update with a zero divisor")
  `GF2PI_ASSERT_IMPL(a_result_source, $rose(out_valid_r), $past(state_r == S_AFTER) && $past(phase_r == PH_F2), "result raised outside the final division")

endmodule

FILE: rtl/gf2_poly_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_poly_inverse
// Inverse of a binary polynomial modulo a programmable binary polynomial,
// computed by the extended Euclidean algorithm with a bit-serial divider.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload              Meaning
//   in_ch    in   element[W-1:0]       polynomial to invert, one per beat
//   out_ch   out  inverse[W-1:0]      one result beat per input beat
//   cfg_ch   in   modulus_poly[W-1:0]  modulus register write, always ready
//
// One item runs one division per Euclid step plus two closing divisions.
// In a division the divisor is first shifted up one bit a cycle until its
// leading term reaches the top bit, then the quotient is produced one bit a
// cycle, high to low. A zero divisor skips both steps.
// Reset (synchronous, rst_n low) loads the modulus with x^8+x^4+x^3+x^2+1 and
// empties the controller and the output register; no clearing pass is needed.
// A stalled result waits in the output register; the next beat is taken while
// it waits, and only the final capture of that next item stalls behind it.
//
module gf2_poly_inverse #(
  parameter int POLY_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  gf2pi_in_if.sink           in_ch,
  gf2pi_out_if.source        out_ch,
  gf2pi_cfg_if.sink          cfg_ch
);

  gf2pi_pkg::cmd_t cmd;
  gf2pi_pkg::sts_t sts;

  // The modulus register takes a write in any cycle. The user must reprogram
  // the block only between items; the block itself does not enforce this.
  assign cfg_ch.ready = 1'b1;

  // Controller: walks the Euclid loop, then divides the modulus by the gcd
  // and reduces the Bezout coefficient by that quotient.
  gf2pi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: Euclid registers, one shared serial divider whose quotient
  // bits also drive the carry-less product for the coefficient update.
  gf2pi_dp #(
    .W (POLY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .element_i  (in_ch.element),
    .cfg_we_i   (cfg_ch.valid),
    .cfg_data_i (cfg_ch.modulus_poly),
    .inverse_o  (out_ch.inverse)
  );

endmodule
